FILE: rtl/arp_responder_and_cache_defines.svh
// ----------------------------------------------------------------------------
// ARP responder assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ARP_RESPONDER_AND_CACHE_DEFINES_SVH
`define ARP_RESPONDER_AND_CACHE_DEFINES_SVH

// Assertion on an explicit clock and active-low reset.
`define ARPC_ASSERT_CR(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion on the block clock and reset.
`define ARPC_ASSERT(lbl, prop, msg) \
  `ARPC_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP responder package
// Shared types, field codes and table sizing for the ARP responder and cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ENTRY_W = 32 + 48;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'b1;

  // Commands
  localparam logic CMD_RX    = 1'b0;
  localparam logic CMD_PROBE = 1'b1;

  // ARP header codes
  localparam logic [15:0] HW_TYPE_ETH    = 16'h0001;
  localparam logic [15:0] PROTO_IPV4     = 16'h0800;
  localparam logic [7:0]  HW_LEN_ETH     = 8'd6;
  localparam logic [7:0]  PROTO_LEN_IPV4 = 8'd4;
  localparam logic [15:0] OP_REQUEST     = 16'd1;
  localparam logic [15:0] OP_REPLY       = 16'd2;

  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    OUT_DROP    = 2'd0,
    OUT_REPLY   = 2'd1,
    OUT_REQUEST = 2'd2,
    OUT_LEARN   = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    TX_OP_NONE    = 2'd0,
    TX_OP_REQUEST = 2'd1,
    TX_OP_REPLY   = 2'd2
  } tx_op_e;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_EVAL,
    CTL_WAIT
  } ctl_state_e;

  typedef enum logic [1:0] {
    TBL_IDLE,
    TBL_SCAN,
    TBL_WRITE
  } tbl_state_e;

  typedef struct packed {
    logic        command;
    logic [15:0] hw_type;
    logic [15:0] ptype;
    logic [7:0]  hw_len;
    logic [7:0]  plen;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [47:0] target_mac;
    logic [31:0] target_ip;
  } arp_in_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [1:0]  tx_opcode;
    logic [47:0] tx_eth_dest;
    logic [47:0] tx_target_mac;
    logic [31:0] tx_target_ip;
    logic [31:0] tx_sender_ip;
    logic [31:0] learned_ip;
    logic [47:0] learned_mac;
    logic        replaced_existing;
  } arp_res_t;

  typedef struct packed {
    logic        start;
    logic [31:0] ip;
    logic [47:0] mac;
  } tbl_req_t;

  typedef struct packed {
    logic done;
    logic existed;
  } tbl_rsp_t;

endpackage

FILE: rtl/arp_responder_and_cache.sv
// ----------------------------------------------------------------------------
// ARP responder and address cache
// Answers ARP requests for our IP, learns bindings from replies sent to us,
// and issues broadcast probe requests.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_i and raise start while busy is low; the
//   item is taken at that clock edge and busy rises on the next cycle.
//   Result channel: every item gives one result beat on res_o, marked by
//   res_valid_o for exactly one cycle. The receiver cannot stall it.
//   Config channel: cfg_index_i selects own_mac (0) or own_ip (1); a write
//   completes when cfg_valid_i and cfg_ready_o are both high. Write only
//   while busy is low and no result is pending.
// Sequencing:
//   Drops, probes and answered requests: the item is evaluated in the EVAL
//   state and its result is registered; no new item is taken until IDLE.
//   Learning replies: the table search reads one entry per cycle from the
//   entry RAM, and the result is registered once the binding is written;
//   a hit ends the search early.
// Reset:
//   Clears the valid bits of all table entries, the round-robin pointer,
//   both configuration registers and the control state.
// ----------------------------------------------------------------------------
module arp_responder_and_cache (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  arpc_pkg::arp_in_t                   req_i,
  output logic                                res_valid_o,
  output arpc_pkg::arp_res_t                  res_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [47:0]                         cfg_data_i
);

  import arpc_pkg::*;

  ctl_state_e state_q, state_d;

  logic [47:0] own_mac_q;
  logic [31:0] own_ip_q;
  arp_in_t     item_q;
  arp_res_t    res_q, res_d;
  logic        res_valid_q;

  logic     accept;
  logic     hdr_ok;
  logic     is_probe;
  logic     is_learn;
  logic     is_answer;
  logic     res_load;
  tbl_req_t tbl_req;
  tbl_rsp_t tbl_rsp;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign hdr_ok = (item_q.hw_type == HW_TYPE_ETH) && (item_q.ptype == PROTO_IPV4) &&
                  (item_q.hw_len == HW_LEN_ETH) && (item_q.plen == PROTO_LEN_IPV4);
  assign is_probe  = (item_q.command == CMD_PROBE);
  assign is_learn  = !is_probe && hdr_ok && (item_q.opcode == OP_REPLY) &&
                     (item_q.target_mac == own_mac_q);
  assign is_answer = !is_probe && hdr_ok && (item_q.opcode == OP_REQUEST) &&
                     (item_q.target_ip == own_ip_q);

  arpc_table u_table (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (tbl_req),
    .rsp_o (tbl_rsp)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CTL_IDLE: begin
        if (accept) state_d = CTL_EVAL;
      end
      CTL_EVAL: state_d = is_learn ? CTL_WAIT : CTL_IDLE;
      CTL_WAIT: begin
        if (tbl_rsp.done) state_d = CTL_IDLE;
      end
      default: state_d = CTL_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy          = 1'b1;
    res_load      = 1'b0;
    tbl_req.start = 1'b0;
    tbl_req.ip    = item_q.sender_ip;
    tbl_req.mac   = item_q.sender_mac;
    res_d         = '0;
    case (state_q)
      CTL_IDLE: busy = 1'b0;
      CTL_EVAL: begin
        if (is_learn) begin
          tbl_req.start = 1'b1;
        end else begin
          res_load = 1'b1;
          if (is_probe) begin
            res_d.outcome      = OUT_REQUEST;
            res_d.tx_opcode    = TX_OP_REQUEST;
            res_d.tx_eth_dest  = BCAST_MAC;
            res_d.tx_target_ip = item_q.target_ip;
          end else if (is_answer) begin
            res_d.outcome       = OUT_REPLY;
            res_d.tx_opcode     = TX_OP_REPLY;
            res_d.tx_eth_dest   = item_q.sender_mac;
            res_d.tx_target_mac = item_q.sender_mac;
            res_d.tx_target_ip  = item_q.sender_ip;
            res_d.tx_sender_ip  = own_ip_q;
          end
        end
      end
      CTL_WAIT: begin
        res_load                = tbl_rsp.done;
        res_d.outcome           = OUT_LEARN;
        res_d.learned_ip        = item_q.sender_ip;
        res_d.learned_mac       = item_q.sender_mac;
        res_d.replaced_existing = tbl_rsp.existed;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTL_IDLE;
      res_valid_q <= 1'b0;
      own_mac_q   <= '0;
      own_ip_q    <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_load;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_OWN_MAC: own_mac_q <= cfg_data_i;
          REG_OWN_IP:  own_ip_q  <= cfg_data_i[31:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= req_i;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/arpc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/arpc_table.sv
// ----------------------------------------------------------------------------
// ARP binding table
// Sequential search over the entry RAM with one shared IP comparator,
// then placement of the binding: in place, first free entry, or round-robin.
// ----------------------------------------------------------------------------
module arpc_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  arpc_pkg::tbl_req_t req_i,
  output arpc_pkg::tbl_rsp_t rsp_o
);

  import arpc_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  tbl_state_e state_q, state_d;

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [31:0]      ip_q;
  logic [47:0]      mac_q;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0] chk_idx_q, chk_idx_d;
  logic             chk_valid_q, chk_valid_d;
  logic             free_found_q, free_found_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic             existed_q, existed_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;

  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               hit;
  logic               chk_free;
  logic               last;
  logic               free_now;

  arpc_ram #(
    .Width(ENTRY_W),
    .Depth(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_q),
    .wdata_i({ip_q, mac_q}),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

  // Shared compare on the entry read back in the cycle after its address
  assign hit      = chk_valid_q && valid_q[chk_idx_q] && (ram_rdata[ENTRY_W-1:48] == ip_q);
  assign chk_free = chk_valid_q && !valid_q[chk_idx_q];
  assign last     = chk_valid_q && (chk_idx_q == LAST_IDX);
  assign free_now = free_found_q || chk_free;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      TBL_IDLE: begin
        if (req_i.start) state_d = TBL_SCAN;
      end
      TBL_SCAN: begin
        if (hit || last) state_d = TBL_WRITE;
      end
      TBL_WRITE: state_d = TBL_IDLE;
      default:   state_d = TBL_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ram_we        = 1'b0;
    rsp_o.done    = 1'b0;
    rsp_o.existed = existed_q;
    case (state_q)
      TBL_WRITE: begin
        ram_we     = 1'b1;
        rsp_o.done = 1'b1;
      end
      default: ;
    endcase
  end

  // Scan datapath
  always_comb begin
    rd_idx_d     = rd_idx_q;
    chk_idx_d    = chk_idx_q;
    chk_valid_d  = chk_valid_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    slot_d       = slot_q;
    existed_d    = existed_q;
    ptr_d        = ptr_q;
    case (state_q)
      TBL_IDLE: begin
        rd_idx_d     = '0;
        chk_valid_d  = 1'b0;
        free_found_d = 1'b0;
        existed_d    = 1'b0;
      end
      TBL_SCAN: begin
        rd_idx_d    = (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
        chk_idx_d   = rd_idx_q;
        chk_valid_d = 1'b1;
        if (chk_free && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = chk_idx_q;
        end
        if (hit) begin
          slot_d    = chk_idx_q;
          existed_d = 1'b1;
        end else if (last) begin
          if (free_now) begin
            slot_d = free_found_q ? free_idx_q : chk_idx_q;
          end else begin
            // table full: evict and advance
            slot_d = ptr_q;
            ptr_d  = (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= TBL_IDLE;
      valid_q      <= '0;
      ptr_q        <= '0;
      chk_valid_q  <= 1'b0;
      free_found_q <= 1'b0;
      existed_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      ptr_q        <= ptr_d;
      chk_valid_q  <= chk_valid_d;
      free_found_q <= free_found_d;
      existed_q    <= existed_d;
      if (ram_we) begin
        valid_q[slot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == TBL_IDLE && req_i.start) begin
      ip_q  <= req_i.ip;
      mac_q <= req_i.mac;
    end
    rd_idx_q   <= rd_idx_d;
    chk_idx_q  <= chk_idx_d;
    free_idx_q <= free_idx_d;
    slot_q     <= slot_d;
  end

endmodule

FILE: rtl/arpc_checker.sv
// ----------------------------------------------------------------------------
// ARP responder port checker
// Checks command/result sequencing seen on the top-level ports.
// ----------------------------------------------------------------------------
`include "arp_responder_and_cache_defines.svh"

module arpc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               res_valid_o,
  input arpc_pkg::arp_res_t res_o
);

  import arpc_pkg::*;

  `ARPC_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted command did not raise busy")
  `ARPC_ASSERT(a_res_idle, res_valid_o |-> !busy, "result beat while busy")
  `ARPC_ASSERT(a_busy_end_res, $fell(busy) |-> res_valid_o, "busy dropped without a result beat")
  `ARPC_ASSERT(a_drop_zero, (res_valid_o && res_o.outcome == OUT_DROP) |-> (res_o.tx_opcode == TX_OP_NONE && res_o.learned_ip == 32'd0), "dropped item carries fields")

endmodule

bind arp_responder_and_cache arpc_checker u_arpc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARP responder and address cache testbench
// Drives probes and parsed ARP packets through the command port, mirrors the
// binding table and both address registers in a local predictor, and checks
// every result beat field by field against the expectation taken at accept.
// ----------------------------------------------------------------------------
module testbench;
  import arpc_pkg::*;

  localparam int IP_POOL_SIZE = 24;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start_drv   = 1'b0;
  arp_in_t              pkt_drv     = '0;
  logic                 cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = REG_OWN_MAC;
  logic [47:0]          cfg_data    = '0;
  logic                 busy;
  logic                 res_valid;
  arp_res_t             res;
  logic                 cfg_ready;

  // Local copy of the block's state
  logic [47:0] my_mac;
  logic [31:0] my_ip;
  bit          cache_valid [TABLE_ENTRIES];
  logic [31:0] cache_ip    [TABLE_ENTRIES];
  logic [47:0] cache_mac   [TABLE_ENTRIES];
  int          evict_ptr;

  arp_res_t    arp_outcome_q[$];
  logic [31:0] ip_pool [IP_POOL_SIZE];

  int mismatches  = 0;
  int items_sent  = 0;
  int n_probe     = 0;
  int n_answered  = 0;
  int n_learned   = 0;
  int n_in_place  = 0;
  int n_evicted   = 0;
  int n_dropped   = 0;

  arp_responder_and_cache u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start_drv),
    .busy        (busy),
    .req_i       (pkt_drv),
    .res_valid_o (res_valid),
    .res_o       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [47:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Work out the result of one accepted item and update the local table.
  function automatic arp_res_t resolve_arp(arp_in_t pkt);
    arp_res_t r;
    int       slot;
    bit       existed;
    r       = '0;
    slot    = -1;
    existed = 1'b0;
    if (pkt.command == CMD_PROBE) begin
      r.outcome      = OUT_REQUEST;
      r.tx_opcode    = TX_OP_REQUEST;
      r.tx_eth_dest  = BCAST_MAC;
      r.tx_target_ip = pkt.target_ip;
      n_probe++;
      return r;
    end
    if (pkt.hw_type != HW_TYPE_ETH || pkt.ptype != PROTO_IPV4 ||
        pkt.hw_len != HW_LEN_ETH || pkt.plen != PROTO_LEN_IPV4) begin
      n_dropped++;
      return r;
    end
    if (pkt.opcode == OP_REPLY && pkt.target_mac == my_mac) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (cache_valid[i] && cache_ip[i] == pkt.sender_ip) begin
          slot    = i;
          existed = 1'b1;
          break;
        end
      end
      if (slot < 0) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (!cache_valid[i]) begin
            slot = i;
            break;
          end
        end
      end
      // Table full: evict round-robin
      if (slot < 0) begin
        slot      = evict_ptr;
        evict_ptr = (evict_ptr == TABLE_ENTRIES - 1) ? 0 : evict_ptr + 1;
        n_evicted++;
      end
      cache_valid[slot]   = 1'b1;
      cache_ip[slot]      = pkt.sender_ip;
      cache_mac[slot]     = pkt.sender_mac;
      r.outcome           = OUT_LEARN;
      r.learned_ip        = pkt.sender_ip;
      r.learned_mac       = pkt.sender_mac;
      r.replaced_existing = existed;
      n_learned++;
      if (existed) n_in_place++;
    end else if (pkt.opcode == OP_REQUEST && pkt.target_ip == my_ip) begin
      r.outcome       = OUT_REPLY;
      r.tx_opcode     = TX_OP_REPLY;
      r.tx_eth_dest   = pkt.sender_mac;
      r.tx_target_mac = pkt.sender_mac;
      r.tx_target_ip  = pkt.sender_ip;
      r.tx_sender_ip  = my_ip;
      n_answered++;
    end else begin
      n_dropped++;
    end
    return r;
  endfunction

  function automatic void check_field(string fname, logic [47:0] want, logic [47:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s: expected %h, got %h", fname, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    arp_res_t want;
    if (rst_ni && res_valid) begin
      if (arp_outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH unexpected result beat: %h", res);
      end else begin
        want = arp_outcome_q.pop_front();
        check_field("outcome",           want.outcome,           res.outcome);
        check_field("tx_opcode",         want.tx_opcode,         res.tx_opcode);
        check_field("tx_eth_dest",       want.tx_eth_dest,       res.tx_eth_dest);
        check_field("tx_target_mac",     want.tx_target_mac,     res.tx_target_mac);
        check_field("tx_target_ip",      want.tx_target_ip,      res.tx_target_ip);
        check_field("tx_sender_ip",      want.tx_sender_ip,      res.tx_sender_ip);
        check_field("learned_ip",        want.learned_ip,        res.learned_ip);
        check_field("learned_mac",       want.learned_mac,       res.learned_mac);
        check_field("replaced_existing", want.replaced_existing, res.replaced_existing);
      end
    end
  end

  // Send one item; start stays high after the beat so that back-to-back
  // items need no second assignment in one step.
  task automatic send_pkt(arp_in_t pkt);
    @(negedge clk_i);
    pkt_drv   <= pkt;
    start_drv <= 1'b1;
    do @(posedge clk_i); while (busy);
    arp_outcome_q.push_back(resolve_arp(pkt));
    items_sent++;
  endtask

  task automatic idle(int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      start_drv <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // Hold off the sender until every pending result has come back.
  task automatic drain();
    idle(1);
    while (arp_outcome_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == REG_OWN_MAC) my_mac = data;
    else                    my_ip  = data[31:0];
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic arp_in_t good_hdr(logic [15:0] op);
    arp_in_t p;
    p.command    = CMD_RX;
    p.hw_type    = HW_TYPE_ETH;
    p.ptype      = PROTO_IPV4;
    p.hw_len     = HW_LEN_ETH;
    p.plen       = PROTO_LEN_IPV4;
    p.opcode     = op;
    p.sender_mac = rand_mac();
    p.sender_ip  = $urandom;
    p.target_mac = rand_mac();
    p.target_ip  = $urandom;
    return p;
  endfunction

  function automatic logic [31:0] pick_ip();
    return ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                       : ip_pool[$urandom_range(0, IP_POOL_SIZE - 1)];
  endfunction

  // Mostly well-formed requests and replies with random addresses; the rest
  // probes, broken headers and unknown opcodes.
  function automatic arp_in_t make_random_pkt();
    arp_in_t p;
    int      kind;
    kind = $urandom_range(0, 99);
    p = good_hdr(OP_REPLY);
    p.sender_ip = pick_ip();
    if (kind < 15) begin
      p = $bits(arp_in_t)'({$urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom});
      p.command   = CMD_PROBE;
      p.target_ip = pick_ip();
    end else if (kind < 40) begin
      p.opcode = OP_REQUEST;
      if ($urandom_range(0, 4) != 0) p.target_ip = my_ip;
    end else if (kind < 80) begin
      if ($urandom_range(0, 6) != 0) p.target_mac = my_mac;
    end else if (kind < 90) begin
      if ($urandom_range(0, 1) != 0) p.target_mac = my_mac;
      case ($urandom_range(0, 3))
        0: p.hw_type = 16'($urandom);
        1: p.ptype   = 16'($urandom);
        2: p.hw_len  = 8'($urandom);
        default: p.plen = 8'($urandom);
      endcase
    end else begin
      p.target_mac = my_mac;
      p.target_ip  = my_ip;
      p.opcode     = 16'($urandom);
    end
    return p;
  endfunction

  // Registers still hold their reset values of zero.
  task automatic test_reset_state();
    arp_in_t p;
    p = good_hdr(OP_REQUEST);
    p.target_ip = '0;
    send_pkt(p);
    p = good_hdr(OP_REPLY);
    p.target_mac = '0;
    send_pkt(p);
    drain();
  endtask

  task automatic test_directed();
    arp_in_t p;
    write_reg(REG_OWN_MAC, 48'h0200_5E10_2030);
    write_reg(REG_OWN_IP,  48'h0000_C0A8_0001);
    // probes ignore everything but target_ip
    p = '1;
    p.command = CMD_PROBE;
    send_pkt(p);
    p = $bits(arp_in_t)'({$urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom});
    p.command   = CMD_PROBE;
    p.target_ip = '0;
    send_pkt(p);
    p = good_hdr(OP_REQUEST);
    p.target_ip = my_ip;
    send_pkt(p);
    p.target_ip = my_ip ^ 32'h1;
    send_pkt(p);
    p = good_hdr(OP_REPLY);
    p.target_mac = my_mac;
    send_pkt(p);
    p.sender_mac = rand_mac();
    send_pkt(p);
    p.target_mac = my_mac ^ 48'h8000_0000_0000;
    send_pkt(p);
    p.target_mac = my_mac;
    p.hw_type    = 16'hFFFF;
    send_pkt(p);
    p.hw_type    = HW_TYPE_ETH;
    p.ptype      = 16'h0806;
    send_pkt(p);
    p.ptype      = PROTO_IPV4;
    p.hw_len     = 8'hFF;
    send_pkt(p);
    p.hw_len     = HW_LEN_ETH;
    p.plen       = 8'h00;
    send_pkt(p);
    p.plen       = PROTO_LEN_IPV4;
    p.target_ip  = my_ip;
    p.opcode     = 16'h0000;
    send_pkt(p);
    p.opcode     = 16'h0003;
    send_pkt(p);
    p.opcode     = 16'hFFFF;
    send_pkt(p);
    p.opcode     = OP_REPLY;
    p.sender_mac = '1;
    p.sender_ip  = '1;
    send_pkt(p);
    p.sender_mac = '0;
    p.sender_ip  = '0;
    send_pkt(p);
    p.opcode     = OP_REQUEST;
    p.sender_mac = '1;
    p.sender_ip  = '1;
    send_pkt(p);
    drain();
  endtask

  task automatic test_random_phase(int count, logic [47:0] mac, logic [47:0] ip);
    int burst_left;
    burst_left = 0;
    write_reg(REG_OWN_MAC, mac);
    write_reg(REG_OWN_IP,  ip);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) drain();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
      end
      burst_left--;
      send_pkt(make_random_pkt());
    end
    drain();
  endtask

  initial begin
    foreach (cache_valid[i]) begin
      cache_valid[i] = 1'b0;
      cache_ip[i]    = '0;
      cache_mac[i]   = '0;
    end
    evict_ptr = 0;
    my_mac    = '0;
    my_ip     = '0;
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    for (int i = 2; i < IP_POOL_SIZE; i++) ip_pool[i] = $urandom;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_directed();
    test_random_phase(250, rand_mac(), {16'($urandom), 32'($urandom)});
    test_random_phase(250, '1, '1);
    test_random_phase(250, '0, '0);
    test_random_phase(250, 48'h0000_0000_0001, 48'hFFFF_8000_0000);
    test_random_phase(250, rand_mac(), {16'h0, ip_pool[$urandom_range(2, IP_POOL_SIZE - 1)]});

    // catch any stray beat after the last expected one
    repeat (40) @(posedge clk_i);

    $display("Run covered %0d items: %0d probes, %0d requests answered, %0d dropped,",
             items_sent, n_probe, n_answered, n_dropped);
    $display("  %0d bindings learned, %0d replaced in place, %0d round-robin evictions.",
             n_learned, n_in_place, n_evicted);
    if (mismatches == 0 && arp_outcome_q.size() == 0) begin
      $display("arp_responder_and_cache verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, arp_outcome_q.size());
      $display("arp_responder_and_cache verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results pending", arp_outcome_q.size());
    $display("arp_responder_and_cache verification failed");
    $finish;
  end

endmodule
